// File: sv/sxfb_pkg.sv
`timescale 1ns / 1ps
// shared types and constants for the sprite xor framebuffer
// used by the controller, the datapath, the top level and the checker
package sxfb_pkg;

    localparam int DEF_SCREEN_WIDTH  = 64;
    localparam int DEF_SCREEN_HEIGHT = 32;

    // a display row is always carried as one 64-bit word, leftmost pixel in the msb
    localparam int ROW_BITS    = 64;
    localparam int COL_W       = 6;
    localparam int SPRITE_MSB  = 7;
    localparam int SPRITE_BITS = SPRITE_MSB + 1;

    // fixed-point reciprocal for the coordinate wrap
    localparam int RECIP_SHIFT = 16;
    localparam int PROD_W      = 24;
    localparam int QUOT_W      = 5;
    localparam int REM_W       = 16;

    localparam int CMD_W = 2;
    localparam logic [CMD_W-1:0] CMD_DRAW  = 2'd0;
    localparam logic [CMD_W-1:0] CMD_CLEAR = 2'd1;
    localparam logic [CMD_W-1:0] CMD_READ  = 2'd2;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DIV,
        ST_IDX,
        ST_RD,
        ST_WR,
        ST_OUT
    } ctrl_state_t;

    // controller to datapath
    typedef struct packed {
        logic load;
        logic div_en;
        logic idx_en;
        logic rd_en;
        logic wr_en;
        logic out_load;
    } dp_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic out_free;
    } dp_sts_t;

endpackage

// File: sv/sxfb_ctrl.sv
`timescale 1ns / 1ps
// sequencing state machine for the sprite xor framebuffer
// depends on sxfb_pkg for the state type and the command and status structs
module sxfb_ctrl import sxfb_pkg::*; (
    input  logic    aclk,
    input  logic    aresetn,
    input  logic    s_valid,
    output logic    s_ready,
    output dp_cmd_t ctl,
    input  dp_sts_t sts
);

    ctrl_state_t state_reg;
    ctrl_state_t state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        ctl        = '0;
        s_ready    = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    ctl.load   = 1'b1;
                    state_next = ST_DIV;
                end
            end
            ST_DIV: begin
                ctl.div_en = 1'b1;
                state_next = ST_IDX;
            end
            ST_IDX: begin
                ctl.idx_en = 1'b1;
                state_next = ST_RD;
            end
            ST_RD: begin
                ctl.rd_en  = 1'b1;
                state_next = ST_WR;
            end
            ST_WR: begin
                ctl.wr_en  = 1'b1;
                state_next = ST_OUT;
            end
            ST_OUT: begin
                // once the output register is free, hand the word to it and take the next item at once
                if (sts.out_free) begin
                    ctl.out_load = 1'b1;
                    s_ready      = 1'b1;
                    if (s_valid) begin
                        ctl.load   = 1'b1;
                        state_next = ST_DIV;
                    end else begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

// File: sv/sxfb_datapath.sv
`timescale 1ns / 1ps
// datapath: coordinate wrap, row memory read-modify-write and output register
// depends on sxfb_pkg; driven by sxfb_ctrl through dp_cmd_t
module sxfb_datapath import sxfb_pkg::*; #(
    parameter int SCREEN_WIDTH  = DEF_SCREEN_WIDTH,
    parameter int SCREEN_HEIGHT = DEF_SCREEN_HEIGHT
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  dp_cmd_t             ctl,
    output dp_sts_t             sts,
    input  logic [CMD_W-1:0]    s_cmd,
    input  logic [7:0]          s_x_pos,
    input  logic [7:0]          s_y_pos,
    input  logic [3:0]          s_row_index,
    input  logic [7:0]          s_row_bits,
    output logic                m_valid,
    input  logic                m_ready,
    output logic [ROW_BITS-1:0] m_row_data
);

    localparam int AW      = $clog2(SCREEN_HEIGHT);
    localparam int ROW_W   = $clog2(SCREEN_HEIGHT + 16);
    localparam int RECIP_X = (2**RECIP_SHIFT + SCREEN_WIDTH - 1) / SCREEN_WIDTH;
    localparam int RECIP_Y = (2**RECIP_SHIFT + SCREEN_HEIGHT - 1) / SCREEN_HEIGHT;
    localparam logic [ROW_BITS-1:0] COL_MASK = ~(ROW_BITS'(0)) << (ROW_BITS - SCREEN_WIDTH);

    // item registers
    logic [CMD_W-1:0] cmd_reg;
    logic [7:0]       x_reg;
    logic [7:0]       y_reg;
    logic [3:0]       ri_reg;
    logic [7:0]       bits_reg;

    // wrap quotients
    logic [QUOT_W-1:0] qx_reg;
    logic [QUOT_W-1:0] qy_reg;
    logic [PROD_W-1:0] x_prod;
    logic [PROD_W-1:0] y_prod;

    // wrapped coordinates
    logic [REM_W-1:0] x_rem;
    logic [REM_W-1:0] y_rem;
    logic [ROW_W-1:0] row_sum;
    logic [COL_W-1:0] sx_reg;
    logic [COL_W-1:0] ry_reg;
    logic [ROW_W-1:0] row_reg;
    logic             row_ok_reg;

    // memory access
    logic [ROW_BITS-1:0] mem [SCREEN_HEIGHT];
    logic [SCREEN_HEIGHT-1:0] valid_reg;
    logic [AW-1:0]       rd_addr;
    logic [AW-1:0]       addr_reg;
    logic [ROW_BITS-1:0] mem_q_reg;
    logic                hit_reg;
    logic [ROW_BITS-1:0] mask_reg;
    logic [ROW_BITS-1:0] cur_row;

    logic                m_valid_reg;
    logic [ROW_BITS-1:0] m_row_data_reg;

    always_ff @(posedge aclk) begin
        if (ctl.load) begin
            cmd_reg  <= s_cmd;
            x_reg    <= s_x_pos;
            y_reg    <= s_y_pos;
            ri_reg   <= s_row_index;
            bits_reg <= s_row_bits;
        end
    end

    // ceiling reciprocal is exact for 8-bit operands and divisors from 8 to 64 (5-bit quotient field)
    assign x_prod = PROD_W'(x_reg) * PROD_W'(RECIP_X);
    assign y_prod = PROD_W'(y_reg) * PROD_W'(RECIP_Y);

    always_ff @(posedge aclk) begin
        if (ctl.div_en) begin
            qx_reg <= x_prod[RECIP_SHIFT +: QUOT_W];
            qy_reg <= y_prod[RECIP_SHIFT +: QUOT_W];
        end
    end

    assign x_rem   = REM_W'(x_reg) - REM_W'(qx_reg) * REM_W'(SCREEN_WIDTH);
    assign y_rem   = REM_W'(y_reg) - REM_W'(qy_reg) * REM_W'(SCREEN_HEIGHT);
    assign row_sum = ROW_W'(y_rem[COL_W-1:0]) + ROW_W'(ri_reg);

    always_ff @(posedge aclk) begin
        if (ctl.idx_en) begin
            sx_reg     <= x_rem[COL_W-1:0];
            ry_reg     <= y_rem[COL_W-1:0];
            row_reg    <= row_sum;
            row_ok_reg <= (row_sum < ROW_W'(SCREEN_HEIGHT));
        end
    end

    assign rd_addr = (cmd_reg == CMD_READ) ? ry_reg[AW-1:0] : row_reg[AW-1:0];

    always_ff @(posedge aclk) begin
        if (ctl.rd_en) begin
            addr_reg  <= rd_addr;
            mem_q_reg <= mem[rd_addr];
            hit_reg   <= valid_reg[rd_addr];
            // sprite pixels past the right edge fall off the shift or the column mask
            mask_reg  <= ({bits_reg, (ROW_BITS - SPRITE_BITS)'(0)} >> sx_reg) & COL_MASK;
        end
    end

    // a row never written since the last clear reads as blank
    assign cur_row = hit_reg ? mem_q_reg : '0;

    always_ff @(posedge aclk) begin
        if (ctl.wr_en && (cmd_reg == CMD_DRAW) && row_ok_reg) begin
            mem[addr_reg] <= cur_row ^ mask_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else if (ctl.wr_en) begin
            if (cmd_reg == CMD_CLEAR) begin
                valid_reg <= '0;
            end else if ((cmd_reg == CMD_DRAW) && row_ok_reg) begin
                valid_reg[addr_reg] <= 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (ctl.out_load) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (ctl.out_load) begin
            m_row_data_reg <= (cmd_reg == CMD_READ) ? cur_row : '0;
        end
    end

    assign sts.out_free = !m_valid_reg || m_ready;
    assign m_valid      = m_valid_reg;
    assign m_row_data   = m_row_data_reg;

endmodule

// File: sv/sprite_xor_framebuffer_top.sv
`timescale 1ns / 1ps
// flow: an accepted item goes through the wrap, index, read and write-back
//   steps, then waits in the output step until the output register is free;
//   the next item is taken only when the word is handed on, one item at a time
// reset: aresetn is synchronous, active low; it clears the per-row valid bits,
//   so the whole display reads blank right away, with no clearing pass
module sprite_xor_framebuffer_top import sxfb_pkg::*; #(
    parameter int SCREEN_WIDTH  = DEF_SCREEN_WIDTH,
    parameter int SCREEN_HEIGHT = DEF_SCREEN_HEIGHT
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  logic [CMD_W-1:0]    s_cmd,
    input  logic [7:0]          s_x_pos,
    input  logic [7:0]          s_y_pos,
    input  logic [3:0]          s_row_index,
    input  logic [7:0]          s_row_bits,
    output logic                m_valid,
    input  logic                m_ready,
    output logic [ROW_BITS-1:0] m_row_data
);

    dp_cmd_t ctl;
    dp_sts_t sts;

    sxfb_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .ctl     (ctl),
        .sts     (sts)
    );

    sxfb_datapath #(
        .SCREEN_WIDTH  (SCREEN_WIDTH),
        .SCREEN_HEIGHT (SCREEN_HEIGHT)
    ) u_datapath (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .ctl         (ctl),
        .sts         (sts),
        .s_cmd       (s_cmd),
        .s_x_pos     (s_x_pos),
        .s_y_pos     (s_y_pos),
        .s_row_index (s_row_index),
        .s_row_bits  (s_row_bits),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_row_data  (m_row_data)
    );

endmodule

// File: sv/sxfb_checker.sv
`timescale 1ns / 1ps
// port-level checks for the sprite xor framebuffer top level
// depends on sxfb_pkg; bound to sprite_xor_framebuffer_top below
module sxfb_checker import sxfb_pkg::*; (
    input logic                aclk,
    input logic                aresetn,
    input logic                s_valid,
    input logic                s_ready,
    input logic                m_valid,
    input logic                m_ready,
    input logic [ROW_BITS-1:0] m_row_data
);

    // no result word survives reset
    a_reset_clears_out: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("m_valid high after reset");

    // a stalled result word holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |=> (m_valid && $stable(m_row_data)))
        else $error("stalled result word changed");

    // one item at a time: the cycle after a word is taken the input is closed
    a_one_in_flight: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> !s_ready)
        else $error("input taken while an item is in flight");

    // a fresh result word only appears after an accepted input word
    a_result_latency: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid) |-> $past(s_valid && s_ready, 6))
        else $error("result word without a matching input word");

endmodule

bind sprite_xor_framebuffer_top sxfb_checker u_sxfb_checker (.*);
